/* src/thkr_pkg.sv */
// Shared types and constants for the tap-hold key resolver.
// No dependencies; every other file except thkr_ram uses this package by scoped names.
package thkr_pkg;

  // Field widths
  localparam int KEY_W  = 6;
  localparam int ACT_W  = 2;
  localparam int TIME_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Defaults
  localparam int NUM_KEYS_DEF = 47;
  localparam logic [TIME_W-1:0] HOLD_TIMEOUT_RST = 16'd200;

  // Result actions
  localparam logic [ACT_W-1:0] ACT_DOWN      = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UP        = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TAP       = 2'd2;
  localparam logic [ACT_W-1:0] ACT_SHIFT_TAP = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_HOLD_EN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIMEOUT = 1'd1;

  // Request from the sequencer to the output stage
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic              judge;   // action comes from the elapsed-time compare
    logic [ACT_W-1:0]  action;  // used when judge is low
    logic              last;
    logic [TIME_W-1:0] now;
  } emit_t;

endpackage

/* src/thkr_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module thkr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 47
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, and registered read; read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/thkr_seq.sv */
// Event sequencer: decides the handling of each event, scans pending keys,
// and drives the press-time RAM. Holds the pending and passthrough bits.
// Depends on thkr_pkg.
module thkr_seq #(
  parameter int NUM_KEYS = thkr_pkg::NUM_KEYS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic                                      in_is_dual_key,
  input  logic [thkr_pkg::KEY_W-1:0]                in_key_index,
  input  logic                                      in_pressed,
  input  logic [thkr_pkg::TIME_W-1:0]               in_event_time,
  input  logic                                      in_modifier_active,
  input  logic                                      tap_hold_en,
  output logic                                      ram_we,
  output logic                                      ram_re,
  output logic [((NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1)-1:0] ram_addr,
  output logic [thkr_pkg::TIME_W-1:0]               ram_wdata,
  output thkr_pkg::emit_t                           emit,
  input  logic                                      emit_ready
);

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_PASS = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [NUM_KEYS-1:0]           pending_r, pending_nxt;
  logic [NUM_KEYS-1:0]           latched_r, latched_nxt;
  logic [NUM_KEYS-1:0]           mask_r, mask_nxt;
  logic [IDX_W-1:0]              scan_idx_r, scan_idx_nxt;
  logic [thkr_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [thkr_pkg::KEY_W-1:0]    ev_key_r, ev_key_nxt;
  logic [thkr_pkg::TIME_W-1:0]   now_r, now_nxt;
  logic [thkr_pkg::ACT_W-1:0]    pass_act_r, pass_act_nxt;
  logic                          fin_pass_r, fin_pass_nxt;
  logic                          cmp_final_r, cmp_final_nxt;
  logic                          last_r, last_nxt;

  logic                          accept;
  logic                          key_ok;
  logic [IDX_W-1:0]              idx;
  logic [NUM_KEYS-1:0]           idx_bit;
  logic [NUM_KEYS-1:0]           scan_bit;
  logic [NUM_KEYS-1:0]           mask_after;
  logic                          pass_now;
  logic                          pass_path;
  logic                          write_path;
  logic                          judge_path;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Classify the incoming event
  assign key_ok   = in_is_dual_key &&
                    ({1'b0, in_key_index} < (thkr_pkg::KEY_W + 1)'(NUM_KEYS));
  assign idx      = in_key_index[IDX_W-1:0];
  assign idx_bit  = NUM_KEYS'(1) << idx;
  assign pass_now = in_pressed && in_modifier_active;
  assign pass_path  = key_ok && (!tap_hold_en || pass_now || latched_r[idx]);
  assign write_path = key_ok && !pass_path && in_pressed;
  assign judge_path = key_ok && !pass_path && !in_pressed && pending_r[idx];

  assign scan_bit   = NUM_KEYS'(1) << scan_idx_r;
  assign mask_after = mask_r & ~scan_bit;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    pending_nxt   = pending_r;
    latched_nxt   = latched_r;
    mask_nxt      = mask_r;
    scan_idx_nxt  = scan_idx_r;
    key_nxt       = key_r;
    ev_key_nxt    = ev_key_r;
    now_nxt       = now_r;
    pass_act_nxt  = pass_act_r;
    fin_pass_nxt  = fin_pass_r;
    cmp_final_nxt = cmp_final_r;
    last_nxt      = last_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = idx;
    ram_wdata     = in_event_time;
    emit          = '0;
    emit.key      = key_r;
    emit.action   = pass_act_r;
    emit.last     = last_r;
    emit.now      = now_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          now_nxt      = in_event_time;
          key_nxt      = in_key_index;
          ev_key_nxt   = in_key_index;
          scan_idx_nxt = '0;
          mask_nxt     = in_pressed ? (pending_r & ~(key_ok ? idx_bit : '0)) : '0;
          fin_pass_nxt = pass_path;
          pass_act_nxt = in_pressed ? thkr_pkg::ACT_DOWN : thkr_pkg::ACT_UP;
          if (pass_path) begin
            latched_nxt[idx] = pass_now;
          end
          if (write_path) begin
            ram_we           = 1'b1;
            pending_nxt[idx] = 1'b1;
          end
          if (judge_path) begin
            ram_re           = 1'b1;
            pending_nxt[idx] = 1'b0;
            last_nxt         = 1'b1;
            cmp_final_nxt    = 1'b1;
            state_nxt        = ST_CMP;
          end else if (in_pressed) begin
            state_nxt = ST_SCAN;
          end else if (pass_path) begin
            last_nxt  = 1'b1;
            state_nxt = ST_PASS;
          end
        end
      end
      ST_SCAN: begin
        ram_addr = scan_idx_r;
        if (mask_r == '0) begin
          last_nxt  = 1'b1;
          state_nxt = fin_pass_r ? ST_PASS : ST_IDLE;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          if (mask_r[scan_idx_r]) begin
            ram_re                  = 1'b1;
            mask_nxt                = mask_after;
            pending_nxt[scan_idx_r] = 1'b0;
            key_nxt                 = thkr_pkg::KEY_W'(scan_idx_r);
            last_nxt                = (mask_after == '0) && !fin_pass_r;
            cmp_final_nxt           = 1'b0;
            state_nxt               = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        emit.valid = 1'b1;
        emit.judge = 1'b1;
        if (emit_ready) begin
          state_nxt = cmp_final_r ? ST_IDLE : ST_SCAN;
        end
      end
      ST_PASS: begin
        // The scan may have reused key_r; emit the event's own key
        emit.valid = 1'b1;
        emit.key   = ev_key_r;
        if (emit_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pending_r <= '0;
      latched_r <= '0;
    end else begin
      state_r   <= state_nxt;
      pending_r <= pending_nxt;
      latched_r <= latched_nxt;
    end
  end

  // Working registers of the current event
  always_ff @(posedge clk) begin
    mask_r      <= mask_nxt;
    scan_idx_r  <= scan_idx_nxt;
    key_r       <= key_nxt;
    ev_key_r    <= ev_key_nxt;
    now_r       <= now_nxt;
    pass_act_r  <= pass_act_nxt;
    fin_pass_r  <= fin_pass_nxt;
    cmp_final_r <= cmp_final_nxt;
    last_r      <= last_nxt;
  end

endmodule

/* src/thkr_out.sv */
// Output stage: resolves tap versus shifted tap from the stored press time,
// or passes the sequencer's action through, and holds one result in the output register. Depends on thkr_pkg.
module thkr_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  thkr_pkg::emit_t             emit,
  output logic                        emit_ready,
  input  logic [thkr_pkg::TIME_W-1:0] press_time,
  input  logic [thkr_pkg::TIME_W-1:0] hold_timeout,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [thkr_pkg::KEY_W-1:0]  out_key,
  output logic [thkr_pkg::ACT_W-1:0]  out_action,
  output logic                        out_last
);

  logic                        out_valid_r;
  logic [thkr_pkg::KEY_W-1:0]  key_r;
  logic [thkr_pkg::ACT_W-1:0]  action_r;
  logic                        last_r;
  logic [thkr_pkg::TIME_W-1:0] elapsed;
  logic [thkr_pkg::ACT_W-1:0]  action;
  logic                        load;

  // Wrapped elapsed time against the hold timeout
  assign elapsed = emit.now - press_time;
  assign action  = !emit.judge ? emit.action :
                   (elapsed < hold_timeout) ? thkr_pkg::ACT_TAP : thkr_pkg::ACT_SHIFT_TAP;

  assign emit_ready = !out_valid_r || out_ready;
  assign load       = emit.valid && emit_ready;

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      key_r    <= emit.key;
      action_r <= action;
      last_r   <= emit.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_key    = key_r;
  assign out_action = action_r;
  assign out_last   = last_r;

endmodule

/* src/tap_hold_key_resolver_core.sv */
// Tap-hold key resolver. One key event is taken at a time. A press first
// emits every other pending key in index order, walking the pending bits one
// key per cycle except while a result is being emitted, and reading that key's
// press time from the RAM. The elapsed-time compare sits between the RAM read
// and the output register. A new event is taken while a result still waits in
// the output register. Press times live in a RAM that needs no clearing;
// pending and passthrough bits are flip-flops reset to 0.
// Depends on thkr_pkg, thkr_ram, thkr_seq and thkr_out.
module tap_hold_key_resolver_core #(
  parameter int NUM_KEYS = thkr_pkg::NUM_KEYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [thkr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [thkr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_is_dual_key,
  input  logic [thkr_pkg::KEY_W-1:0]      in_key_index,
  input  logic                            in_pressed,
  input  logic [thkr_pkg::TIME_W-1:0]     in_event_time,
  input  logic                            in_modifier_active,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [thkr_pkg::KEY_W-1:0]      out_key,
  output logic [thkr_pkg::ACT_W-1:0]      out_action,
  output logic                            out_last
);

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic                        tap_hold_en_r;
  logic [thkr_pkg::TIME_W-1:0] hold_timeout_r;
  logic                        ram_we;
  logic                        ram_re;
  logic [IDX_W-1:0]            ram_addr;
  logic [thkr_pkg::TIME_W-1:0] ram_wdata;
  logic [thkr_pkg::TIME_W-1:0] ram_rdata;
  thkr_pkg::emit_t             emit;
  logic                        emit_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_hold_en_r  <= 1'b0;
      hold_timeout_r <= thkr_pkg::HOLD_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        thkr_pkg::REG_TAP_HOLD_EN:  tap_hold_en_r  <= cfg_wdata[0];
        thkr_pkg::REG_HOLD_TIMEOUT: hold_timeout_r <= cfg_wdata[thkr_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  thkr_seq #(
    .NUM_KEYS (NUM_KEYS)
  ) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_is_dual_key     (in_is_dual_key),
    .in_key_index       (in_key_index),
    .in_pressed         (in_pressed),
    .in_event_time      (in_event_time),
    .in_modifier_active (in_modifier_active),
    .tap_hold_en        (tap_hold_en_r),
    .ram_we             (ram_we),
    .ram_re             (ram_re),
    .ram_addr           (ram_addr),
    .ram_wdata          (ram_wdata),
    .emit               (emit),
    .emit_ready         (emit_ready)
  );

  thkr_ram #(
    .WIDTH (thkr_pkg::TIME_W),
    .DEPTH (NUM_KEYS)
  ) u_press_time (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  thkr_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .emit         (emit),
    .emit_ready   (emit_ready),
    .press_time   (ram_rdata),
    .hold_timeout (hold_timeout_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_key      (out_key),
    .out_action   (out_action),
    .out_last     (out_last)
  );

endmodule

/* src/thkr_checker.sv */
// Port-level checks for the tap-hold key resolver, bound to the top level.
// Depends on thkr_pkg and tap_hold_key_resolver_core.
module thkr_checker #(
  parameter int NUM_KEYS = thkr_pkg::NUM_KEYS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [thkr_pkg::KEY_W-1:0] out_key,
  input logic [thkr_pkg::ACT_W-1:0] out_action,
  input logic                       out_last
);

  // A stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_key) &&
                                   $stable(out_action) && $stable(out_last)))
    else $error("result changed while stalled");

  // The block only goes busy after taking an event
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid))
    else $error("in_ready dropped without an input transfer");

  // Emitted keys stay in range
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_key} < (thkr_pkg::KEY_W + 1)'(NUM_KEYS)))
    else $error("result key out of range");

  // Reset leaves the block idle with no result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

endmodule

bind tap_hold_key_resolver_core thkr_checker #(
  .NUM_KEYS (NUM_KEYS)
) u_thkr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_key    (out_key),
  .out_action (out_action),
  .out_last   (out_last)
);
